// ===== src/lkrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkrc_pkg
// Shared types, constants and arithmetic helpers for the Lehmer keystream
// rotation cipher.
// ----------------------------------------------------------------------------
package lkrc_pkg;

    // generator and symbol range constants
    localparam int GEN_W     = 17;
    localparam int SEED_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int GEN_MULT  = 75;
    localparam int GEN_MOD   = 65537;
    localparam int LOW_MASK  = 65535;
    localparam int SYM_LOW   = 32;
    localparam int SYM_END   = 128;
    localparam int SYM_COUNT = SYM_END - SYM_LOW;
    localparam int PROD_W    = 24;
    localparam int POS_W     = 7;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MODE = 1'b0,
        CFG_SEED = 1'b1
    } lkrc_cfg_idx_t;

    // one beat between the generator stage and the rotation stage
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [GEN_W-1:0]  rot_value;
    } lkrc_beat_t;

    // one generator step: g*75 folded modulo 65537
    function automatic logic [GEN_W-1:0] lkrc_advance(input logic [GEN_W-1:0] g);
        logic [PROD_W-1:0] prod;
        logic [SEED_W-1:0] lo;
        logic [GEN_W-1:0]  hi;
        logic [GEN_W-1:0]  res;
        prod = {{(PROD_W-GEN_W){1'b0}}, g} * PROD_W'(GEN_MULT);
        lo   = prod[SEED_W-1:0];
        hi   = {{(GEN_W-(PROD_W-SEED_W)){1'b0}}, prod[PROD_W-1:SEED_W]};
        if ({1'b0, lo} >= hi)
            res = {1'b0, lo} - hi;
        else
            res = {1'b0, lo} + GEN_W'(GEN_MOD) - hi;
        return res;
    endfunction

    // 12-bit value modulo 3: base-4 digit sum, then a short compare chain
    function automatic logic [1:0] lkrc_mod3(input logic [11:0] v);
        logic [4:0] s;
        s = 5'd0;
        for (int k = 0; k < 6; k++)
            s = s + {3'b000, v[2*k +: 2]};
        if (s >= 5'd12)
            s = s - 5'd12;
        if (s >= 5'd6)
            s = s - 5'd6;
        if (s >= 5'd3)
            s = s - 5'd3;
        return s[1:0];
    endfunction

    // rotation amount: r mod 96 = (r>>5 mod 3)*32 + r[4:0]
    function automatic logic [POS_W-1:0] lkrc_mod96(input logic [GEN_W-1:0] r);
        return {lkrc_mod3(r[GEN_W-1:5]), r[4:0]};
    endfunction

    // rotate a printable byte within 32..127, pass others through
    function automatic logic [BYTE_W-1:0] lkrc_rotate(
        input logic [BYTE_W-1:0] b,
        input logic [GEN_W-1:0]  r,
        input logic              decrypt
    );
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  rot;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] res;
        if (b < BYTE_W'(SYM_LOW) || b >= BYTE_W'(SYM_END)) begin
            res = b;
        end
        else begin
            pos = POS_W'(b - BYTE_W'(SYM_LOW));
            rot = lkrc_mod96(r);
            if (decrypt)
                s = {1'b0, pos} + BYTE_W'(SYM_COUNT) - {1'b0, rot};
            else
                s = {1'b0, pos} + {1'b0, rot};
            if (s >= BYTE_W'(SYM_COUNT))
                s = s - BYTE_W'(SYM_COUNT);
            res = s + BYTE_W'(SYM_LOW);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/lkrc_gen.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkrc_gen
// Input stage: holds the Lehmer generator, advances it once per accepted
// beat and registers the byte together with the new rotation value.
// ----------------------------------------------------------------------------
module lkrc_gen
    import lkrc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                first_of_message,
    input  wire logic [SEED_W-1:0]   initial_seed,
    output logic                     s1_valid,
    input  wire logic                s1_ready,
    output lkrc_beat_t               s1_beat
);

    logic              s1_valid_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [GEN_W-1:0]  gen_next;
    logic [GEN_W-1:0]  gen_base;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // stall only while the held beat cannot move on
    assign in_stall = s1_valid_reg && !s1_ready;
    assign accept   = in_valid && !in_stall;

    // reload from seed at message start, then one generator step
    always_comb
    begin
        gen_base = first_of_message ? {1'b0, initial_seed} : gen_reg;
        gen_next = lkrc_advance(gen_base);
    end

    // generator state and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            gen_reg      <= '0;
        end
        else
        begin
            if (!s1_valid_reg || s1_ready)
                s1_valid_reg <= in_valid;
            if (accept)
                gen_reg <= gen_next;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= data_byte;
    end

    assign s1_valid          = s1_valid_reg;
    assign s1_beat.data_byte = data_reg;
    assign s1_beat.rot_value = gen_reg;

    // generator never leaves 0..65536
    a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg <= GEN_W'(GEN_MOD - 1))
        else $error("generator value out of range");

    // a zero seed at message start keeps the generator at zero
    a_zero_seed: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first_of_message && initial_seed == '0 |=> gen_reg == '0)
        else $error("zero seed did not give zero generator");

    // a held beat keeps its rotation value
    a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_ready |=> $stable(gen_reg))
        else $error("generator moved while beat was held");

endmodule
`default_nettype wire

// ===== src/lkrc_rot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkrc_rot
// Output stage: rotates the byte by the generator value mod 96 and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module lkrc_rot
    import lkrc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cipher_mode,
    input  wire logic                s1_valid,
    output logic                     s1_ready,
    input  wire lkrc_beat_t          s1_beat,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [BYTE_W-1:0]        out_byte
);

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              take;

    // output register frees up when empty or being taken
    assign s1_ready = !out_valid_reg || !out_stall;
    assign take     = s1_valid && s1_ready;

    // rotation within the printable range
    always_comb
    begin
        out_byte_next = lkrc_rotate(s1_beat.data_byte, s1_beat.rot_value, cipher_mode);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_ready)
            out_valid_reg <= s1_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
            out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // printable bytes stay printable
    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        take && s1_beat.data_byte >= BYTE_W'(SYM_LOW)
             && s1_beat.data_byte < BYTE_W'(SYM_END)
        |=> out_byte_reg >= BYTE_W'(SYM_LOW) && out_byte_reg < BYTE_W'(SYM_END))
        else $error("rotated byte left printable range");

    // other bytes pass through untouched
    a_rot_pass: assert property (@(posedge clk) disable iff (!rst_n)
        take && (s1_beat.data_byte < BYTE_W'(SYM_LOW)
             || s1_beat.data_byte >= BYTE_W'(SYM_END))
        |=> out_byte_reg == $past(s1_beat.data_byte))
        else $error("non-printable byte was altered");

    // a stalled output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_byte_reg))
        else $error("stalled output beat changed");

endmodule
`default_nettype wire

// ===== src/lehmer_keystream_rotation_cipher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lehmer_keystream_rotation_cipher
// Byte-stream rotation cipher keyed by a Lehmer generator (x75 mod 65537).
// ----------------------------------------------------------------------------
// The block takes one byte per clock while in_stall is low and returns one
// byte per byte, registered in lkrc_gen and then in the output register. The
// rate is set by the generator recurrence in lkrc_gen: the multiply by 75 and
// the fold modulo 65537 are combinational, and the rotation by the generator
// value mod 96 sits in a separate stage ahead of the output register. A byte
// with first_of_message set reloads the generator from initial_seed before its
// step. The user must write cipher_mode and initial_seed through the cfg port
// only while no byte is in flight; the block itself does not enforce this.
module lehmer_keystream_rotation_cipher
    import lkrc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [SEED_W-1:0]   cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                first_of_message,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [BYTE_W-1:0]        out_byte
);

    logic              mode_reg;
    logic [SEED_W-1:0] seed_reg;
    logic              s1_valid;
    logic              s1_ready;
    lkrc_beat_t        s1_beat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            seed_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (lkrc_cfg_idx_t'(cfg_index))
                CFG_MODE: mode_reg <= cfg_data[0];
                CFG_SEED: seed_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // generator stage
    lkrc_gen u_gen (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .first_of_message (first_of_message),
        .initial_seed     (seed_reg),
        .s1_valid         (s1_valid),
        .s1_ready         (s1_ready),
        .s1_beat          (s1_beat)
    );

    // rotation and output stage
    lkrc_rot u_rot (
        .clk         (clk),
        .rst_n       (rst_n),
        .cipher_mode (mode_reg),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_beat     (s1_beat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte)
    );

endmodule
`default_nettype wire

// ===== bench/tb_lehmer_keystream_rotation_cipher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_lehmer_keystream_rotation_cipher
// Self-checking bench for the Lehmer keystream rotation cipher. A scoreboard
// class keeps its own copy of the generator and the mode and seed registers.
// It predicts each output byte when the input beat is accepted. Output beats
// are compared in order. Directed bytes cover the range edges, both modes and
// the zero-seed case. Random messages follow under several register settings,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_lehmer_keystream_rotation_cipher
    import lkrc_pkg::*;
();

    // predictor and ordered store of expected cipher bytes
    class cipher_scoreboard;
        logic              decrypt;
        logic [SEED_W-1:0] seed;
        logic [GEN_W-1:0]  lehmer;
        logic [BYTE_W-1:0] expected_bytes[$];
        int                fails;

        function new();
            decrypt = 1'b0;
            seed    = '0;
            lehmer  = '0;
            fails   = 0;
        endfunction

        function void write_reg(lkrc_cfg_idx_t idx, logic [SEED_W-1:0] data);
            if (idx == CFG_MODE)
                decrypt = data[0];
            else if (idx == CFG_SEED)
                seed = data;
        endfunction

        // g*75 mod 65537 by folding the high part back onto the low 16 bits
        function logic [GEN_W-1:0] lehmer_step(logic [GEN_W-1:0] g);
            int prod;
            int lo;
            int hi;
            prod = int'(g) * GEN_MULT;
            lo   = prod & LOW_MASK;
            hi   = prod >> 16;
            if (lo >= hi)
                return GEN_W'(lo - hi);
            return GEN_W'(lo + GEN_MOD - hi);
        endfunction

        // shift a printable byte within the 96-symbol window
        function logic [BYTE_W-1:0] shift_symbol(logic [BYTE_W-1:0] b, logic [GEN_W-1:0] r);
            int pos;
            int amount;
            if (b < SYM_LOW || b >= SYM_END)
                return b;
            pos    = int'(b) - SYM_LOW;
            amount = int'(r) % SYM_COUNT;
            if (decrypt)
                pos = (pos + SYM_COUNT - amount) % SYM_COUNT;
            else
                pos = (pos + amount) % SYM_COUNT;
            return BYTE_W'(pos + SYM_LOW);
        endfunction

        function void note_input(logic [BYTE_W-1:0] b, logic first);
            if (first)
                lehmer = {1'b0, seed};
            lehmer = lehmer_step(lehmer);
            expected_bytes.push_back(shift_symbol(b, lehmer));
        endfunction

        function void check_result(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (expected_bytes.size() == 0) begin
                fails++;
                $error("out_byte: no beat expected, actual %0d", got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                fails++;
                $error("out_byte: expected %0d, actual %0d", want, got);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [SEED_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_message;
    logic              out_valid;
    logic              out_stall;
    logic [BYTE_W-1:0] out_byte;

    // no random gaps or stalls while set
    logic              steady;

    cipher_scoreboard  sb = new();

    lehmer_keystream_rotation_cipher dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .first_of_message (first_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // random output stall
    always @(negedge clk)
    begin
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 25);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_byte);
    end

    // one input beat, entered and left at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
        while (!steady && $urandom_range(0, 99) < 25) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        data_byte        <= b;
        first_of_message <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(b, first);
        @(negedge clk);
    endtask

    // stop sending and wait for every expected byte
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // register write, only while no beat is in flight
    task automatic write_reg(input lkrc_cfg_idx_t idx, input logic [SEED_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // random message bytes, mostly printable
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 99) < 75)
            return BYTE_W'($urandom_range(SYM_LOW, SYM_END - 1));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // run limit
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        int               sent;
        int               msg_len;
        logic             first;
        logic [SEED_W-1:0] seed_val;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = 1'b0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        data_byte        = '0;
        first_of_message = 1'b0;
        out_stall        = 1'b0;
        steady           = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // generator still at its reset value of zero, no message start
        send_byte(8'h41, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7F, 1'b0);

        // encrypt with the largest seed, range edges and pass-through bytes
        drain();
        write_reg(CFG_MODE, 16'hFFFE);
        write_reg(CFG_SEED, 16'hFFFF);
        send_byte(8'h20, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);

        // decrypt with the smallest nonzero seed
        drain();
        write_reg(CFG_MODE, 16'h0001);
        write_reg(CFG_SEED, 16'h0001);
        send_byte(8'h20, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h5A, 1'b1);

        // zero seed loaded by a message start
        drain();
        write_reg(CFG_SEED, 16'h0000);
        send_byte(8'h30, 1'b1);
        send_byte(8'h7E, 1'b0);

        // random messages under changing register settings
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            steady = (ph == 5);
            write_reg(CFG_MODE, (16'($urandom) & 16'hFFFE) | 16'(ph % 2));
            case (ph % 4)
                0:       seed_val = 16'hFFFF;
                1:       seed_val = 16'h0000;
                2:       seed_val = 16'h0001;
                default: seed_val = 16'($urandom);
            endcase
            write_reg(CFG_SEED, seed_val);
            sent = 0;
            while (sent < 165) begin
                msg_len = $urandom_range(1, 24);
                for (int k = 0; k < msg_len && sent < 165; k++) begin
                    first = (k == 0);
                    // occasional stray or missing message start
                    if ($urandom_range(0, 9) == 0)
                        first = 1'($urandom_range(0, 1));
                    send_byte(pick_byte(), first);
                    sent++;
                end
            end
        end

        drain();
        steady = 1'b0;
        repeat (8) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
